// ===== sv/coms_pkg.sv =====
package coms_pkg;

    localparam int NUM_DIR    = 6;
    localparam int NUM_ORI    = 24;
    localparam int PATH_DEPTH = 8;
    localparam int PATH_IW    = $clog2(PATH_DEPTH);
    localparam int PATH_NW    = $clog2(PATH_DEPTH + 1);
    localparam int PROG_LEN   = 20;

    typedef logic [2:0]              face_t;
    typedef logic [1:0]              code2_t;
    typedef logic [NUM_DIR-1:0][2:0] ori_t;
    typedef logic [4:0]              upc_t;
    typedef logic [4:0]              sidx_t;

    // direction index 0 U, 1 D, 2 F, 3 B, 4 L, 5 R; identity has face i at direction i
    localparam ori_t ORI_IDENT = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

    localparam code2_t ACT_RESET   = 2'd0;
    localparam code2_t ACT_ROBOT   = 2'd1;
    localparam code2_t ACT_CUBE    = 2'd2;
    localparam code2_t ACT_RESTORE = 2'd3;

    localparam code2_t AX_Y = 2'd0;
    localparam code2_t AX_Z = 2'd1;
    localparam code2_t AX_D = 2'd2;

    localparam code2_t TN_PLUS  = 2'd0;
    localparam code2_t TN_PRIME = 2'd1;
    localparam code2_t TN_HALF  = 2'd2;

    localparam code2_t RK_YP = 2'd0;
    localparam code2_t RK_YM = 2'd1;
    localparam code2_t RK_ZP = 2'd2;
    localparam code2_t RK_ZM = 2'd3;

    localparam face_t DIR_U    = 3'd0;
    localparam face_t DIR_D    = 3'd1;
    localparam face_t DIR_F    = 3'd2;
    localparam face_t DIR_B    = 3'd3;
    localparam face_t DIR_L    = 3'd4;
    localparam face_t DIR_R    = 3'd5;
    localparam face_t DIR_NONE = 3'd6;
    localparam face_t FACE_MAX = 3'd5;

    typedef enum logic [3:0] {
        OP_FETCH    = 4'd0,
        OP_RESET    = 4'd1,
        OP_ROBOT    = 4'd2,
        OP_CUBE_CHK = 4'd3,
        OP_FIX      = 4'd4,
        OP_DMOVE    = 4'd5,
        OP_R_INIT   = 4'd6,
        OP_R_READ   = 4'd7,
        OP_R_EXP    = 4'd8,
        OP_R_BREAD  = 4'd9,
        OP_R_BSTEP  = 4'd10,
        OP_R_EMIT   = 4'd11,
        OP_R_FAIL   = 4'd12
    } op_t;

    localparam upc_t A_FETCH   = 5'd0;
    localparam upc_t A_RESET   = 5'd1;
    localparam upc_t A_ROBOT   = 5'd2;
    localparam upc_t A_CUBE    = 5'd3;
    localparam upc_t A_U_1     = 5'd4;
    localparam upc_t A_U_2     = 5'd5;
    localparam upc_t A_DMOVE   = 5'd6;
    localparam upc_t A_F_1     = 5'd7;
    localparam upc_t A_F_2     = 5'd8;
    localparam upc_t A_B_1     = 5'd9;
    localparam upc_t A_B_2     = 5'd10;
    localparam upc_t A_L_1     = 5'd11;
    localparam upc_t A_R_1     = 5'd12;
    localparam upc_t A_R_INIT  = 5'd13;
    localparam upc_t A_R_READ  = 5'd14;
    localparam upc_t A_R_EXP   = 5'd15;
    localparam upc_t A_R_BREAD = 5'd16;
    localparam upc_t A_R_BSTEP = 5'd17;
    localparam upc_t A_R_FAIL  = 5'd18;
    localparam upc_t A_R_EMIT  = 5'd19;

    typedef struct packed {
        op_t    op;
        code2_t axis;
        code2_t turn;
        upc_t   next;
        upc_t   alt;
    } ucw_t;

    typedef struct packed {
        logic   move_valid;
        code2_t move_axis;
        code2_t move_turn;
        logic   status;
        logic   last;
        ori_t   faces;
    } res_t;

    function automatic ucw_t uw(op_t op, code2_t axis, code2_t turn, upc_t next, upc_t alt);
        ucw_t w;
        w.op   = op;
        w.axis = axis;
        w.turn = turn;
        w.next = next;
        w.alt  = alt;
        return w;
    endfunction

    // control store
    function automatic ucw_t ucode(upc_t a);
        ucw_t w;
        case (a)
            A_FETCH:   w = uw(OP_FETCH,    AX_Y, TN_PLUS,  A_FETCH,   A_FETCH);
            A_RESET:   w = uw(OP_RESET,    AX_Y, TN_PLUS,  A_FETCH,   A_FETCH);
            A_ROBOT:   w = uw(OP_ROBOT,    AX_Y, TN_PLUS,  A_FETCH,   A_FETCH);
            A_CUBE:    w = uw(OP_CUBE_CHK, AX_Y, TN_PLUS,  A_FETCH,   A_FETCH);
            A_U_1:     w = uw(OP_FIX,      AX_Y, TN_PLUS,  A_U_2,     A_FETCH);
            A_U_2:     w = uw(OP_FIX,      AX_Y, TN_PLUS,  A_DMOVE,   A_FETCH);
            A_DMOVE:   w = uw(OP_DMOVE,    AX_D, TN_PLUS,  A_FETCH,   A_FETCH);
            A_F_1:     w = uw(OP_FIX,      AX_Z, TN_PLUS,  A_F_2,     A_FETCH);
            A_F_2:     w = uw(OP_FIX,      AX_Y, TN_PLUS,  A_DMOVE,   A_FETCH);
            A_B_1:     w = uw(OP_FIX,      AX_Z, TN_PLUS,  A_B_2,     A_FETCH);
            A_B_2:     w = uw(OP_FIX,      AX_Y, TN_PRIME, A_DMOVE,   A_FETCH);
            A_L_1:     w = uw(OP_FIX,      AX_Y, TN_PRIME, A_DMOVE,   A_FETCH);
            A_R_1:     w = uw(OP_FIX,      AX_Y, TN_PLUS,  A_DMOVE,   A_FETCH);
            A_R_INIT:  w = uw(OP_R_INIT,   AX_Y, TN_PLUS,  A_R_READ,  A_FETCH);
            A_R_READ:  w = uw(OP_R_READ,   AX_Y, TN_PLUS,  A_R_EXP,   A_R_FAIL);
            A_R_EXP:   w = uw(OP_R_EXP,    AX_Y, TN_PLUS,  A_R_READ,  A_R_BREAD);
            A_R_BREAD: w = uw(OP_R_BREAD,  AX_Y, TN_PLUS,  A_R_BSTEP, A_R_EMIT);
            A_R_BSTEP: w = uw(OP_R_BSTEP,  AX_Y, TN_PLUS,  A_R_BREAD, A_FETCH);
            A_R_FAIL:  w = uw(OP_R_FAIL,   AX_Y, TN_PLUS,  A_FETCH,   A_FETCH);
            A_R_EMIT:  w = uw(OP_R_EMIT,   AX_Y, TN_PLUS,  A_FETCH,   A_FETCH);
            default:   w = uw(OP_FETCH,    AX_Y, TN_PLUS,  A_FETCH,   A_FETCH);
        endcase
        return w;
    endfunction

    function automatic upc_t act_entry(code2_t act);
        upc_t a;
        case (act)
            ACT_RESET: a = A_RESET;
            ACT_ROBOT: a = A_ROBOT;
            ACT_CUBE:  a = A_CUBE;
            default:   a = A_R_INIT;
        endcase
        return a;
    endfunction

    // sequence that brings the face in a direction down
    function automatic upc_t dir_entry(face_t dir);
        upc_t a;
        case (dir)
            DIR_U:   a = A_U_1;
            DIR_F:   a = A_F_1;
            DIR_B:   a = A_B_1;
            DIR_L:   a = A_L_1;
            DIR_R:   a = A_R_1;
            default: a = A_DMOVE;
        endcase
        return a;
    endfunction

    function automatic ori_t rotate(ori_t o, code2_t kind);
        ori_t r;
        r = o;
        case (kind)
            RK_YP:
            begin
                r[DIR_U] = o[DIR_L];
                r[DIR_D] = o[DIR_R];
                r[DIR_L] = o[DIR_D];
                r[DIR_R] = o[DIR_U];
            end
            RK_YM:
            begin
                r[DIR_U] = o[DIR_R];
                r[DIR_D] = o[DIR_L];
                r[DIR_L] = o[DIR_U];
                r[DIR_R] = o[DIR_D];
            end
            RK_ZP:
            begin
                r[DIR_F] = o[DIR_L];
                r[DIR_B] = o[DIR_R];
                r[DIR_L] = o[DIR_B];
                r[DIR_R] = o[DIR_F];
            end
            default:
            begin
                r[DIR_F] = o[DIR_R];
                r[DIR_B] = o[DIR_L];
                r[DIR_L] = o[DIR_F];
                r[DIR_R] = o[DIR_B];
            end
        endcase
        return r;
    endfunction

    function automatic ori_t apply_move(ori_t o, code2_t axis, code2_t turn);
        ori_t r;
        case (axis)
            AX_Y:    r = (turn == TN_PLUS) ? rotate(o, RK_YP) : rotate(o, RK_YM);
            AX_Z:
            begin
                case (turn)
                    TN_PLUS:  r = rotate(o, RK_ZP);
                    TN_PRIME: r = rotate(o, RK_ZM);
                    default:  r = rotate(rotate(o, RK_ZP), RK_ZP);
                endcase
            end
            default: r = o;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/coms_if.sv =====
interface coms_cmd_if
    import coms_pkg::*;
();
    logic   valid;
    logic   ready;
    code2_t action;
    code2_t axis;
    code2_t turn;
    face_t  face;

    modport source (output valid, action, axis, turn, face, input ready);
    modport sink   (input valid, action, axis, turn, face, output ready);
endinterface

interface coms_res_if
    import coms_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   move_valid;
    code2_t move_axis;
    code2_t move_turn;
    logic   status;
    logic   last;
    face_t  face_at_up;
    face_t  face_at_down;
    face_t  face_at_front;
    face_t  face_at_back;
    face_t  face_at_left;
    face_t  face_at_right;

    modport source (output valid, move_valid, move_axis, move_turn, status, last,
                    face_at_up, face_at_down, face_at_front, face_at_back,
                    face_at_left, face_at_right,
                    input ready);
    modport sink   (input valid, move_valid, move_axis, move_turn, status, last,
                    face_at_up, face_at_down, face_at_front, face_at_back,
                    face_at_left, face_at_right,
                    output ready);
endinterface

// ===== sv/cube_orientation_move_sequencer.sv =====
// Cube orientation move sequencer. Keeps the face held in each of the six directions and
// turns each command transfer on cmd into one or more result transfers on res, the last
// one flagged by last. A microcoded control store steps one control word per cycle unless
// an emitting step waits. After the fetch word, a reset or robot move takes a single word;
// a cube face move takes a check word, then a word for each emitted move; a restore takes
// a set-up word, then for each orientation taken from the search queue a read word and up
// to four expansion words, then a read word and a step word for each path step to walk the
// parent links and one more read word to end the walk, and a word for each emitted move.
// The queue head and parent links have registered read ports, hence the read word in each
// round. Every emitting step waits while the output register holds a result not yet taken;
// a new command is taken as soon as the sequencer is back at its fetch word, even with a
// result still waiting.
module cube_orientation_move_sequencer
    import coms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    coms_cmd_if.sink     cmd,
    coms_res_if.source   res
);

    upc_t   upc_reg, upc_next;
    ucw_t   uw_c;

    code2_t axis_reg, axis_next;
    code2_t turn_reg, turn_next;
    face_t  face_reg, face_next;
    face_t  dir_reg, dir_next;
    face_t  dir_c;

    ori_t   ori_reg, ori_next;

    sidx_t  head_reg, head_next;
    sidx_t  count_reg, count_next;
    sidx_t  cur_idx_reg, cur_idx_next;
    code2_t m_reg, m_next;
    sidx_t  c_reg, c_next;
    logic [PATH_NW-1:0] n_reg, n_next;
    logic [PATH_NW-1:0] nm1_c;

    ori_t   cur_reg;
    sidx_t  par_rd_reg;
    code2_t mv_rd_reg;

    ori_t   states_mem [NUM_ORI];
    sidx_t  parent_mem [NUM_ORI];
    code2_t move_mem   [NUM_ORI];
    code2_t path_mem   [PATH_DEPTH];

    logic   wr_en;
    sidx_t  wr_addr;
    ori_t   wr_state;
    sidx_t  wr_parent;
    code2_t wr_move;
    logic   rd_cur;
    logic   rd_back;
    logic   path_we;

    ori_t   p_c;
    logic   seen_c;
    code2_t path_mv_c;

    logic   robot_bad;
    logic   cube_bad;

    logic   out_valid_reg, out_valid_next;
    res_t   res_reg, res_next;
    logic   slot_free;
    logic   emit_req;
    logic   emit_go;

    assign uw_c      = ucode(upc_reg);
    assign slot_free = !out_valid_reg || res.ready;
    assign emit_go   = emit_req && slot_free;
    assign cmd.ready = (uw_c.op == OP_FETCH);

    assign robot_bad = !(axis_reg inside {AX_Y, AX_Z, AX_D})
                    || !(turn_reg inside {TN_PLUS, TN_PRIME, TN_HALF})
                    || (axis_reg == AX_Y && turn_reg == TN_HALF);
    assign cube_bad  = !(turn_reg inside {TN_PLUS, TN_PRIME, TN_HALF})
                    || (face_reg > FACE_MAX) || (dir_reg == DIR_NONE);

    assign p_c       = rotate(cur_reg, m_reg);
    assign nm1_c     = n_reg - PATH_NW'(1);
    assign path_mv_c = path_mem[nm1_c[PATH_IW-1:0]];

    // first direction holding the requested face
    always_comb
    begin
        dir_c = DIR_NONE;
        for (int i = NUM_DIR - 1; i >= 0; i--)
        begin
            if (ori_reg[i] == cmd.face)
            begin
                dir_c = face_t'(i);
            end
        end
    end

    // compare against every orientation queued so far
    always_comb
    begin
        seen_c = 1'b0;
        for (int i = 0; i < NUM_ORI; i++)
        begin
            if (sidx_t'(i) < count_reg && states_mem[i] == p_c)
            begin
                seen_c = 1'b1;
            end
        end
    end

    always_comb
    begin
        upc_next     = upc_reg;
        axis_next    = axis_reg;
        turn_next    = turn_reg;
        face_next    = face_reg;
        dir_next     = dir_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cur_idx_next = cur_idx_reg;
        m_next       = m_reg;
        c_next       = c_reg;
        n_next       = n_reg;

        emit_req            = 1'b0;
        res_next.move_valid = 1'b0;
        res_next.move_axis  = AX_Y;
        res_next.move_turn  = TN_PLUS;
        res_next.status     = 1'b0;
        res_next.last       = 1'b0;
        ori_next            = ori_reg;

        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_state  = ori_reg;
        wr_parent = '0;
        wr_move   = RK_YP;
        rd_cur    = 1'b0;
        rd_back   = 1'b0;
        path_we   = 1'b0;

        case (uw_c.op)
            OP_FETCH:
            begin
                if (cmd.valid)
                begin
                    axis_next = cmd.axis;
                    turn_next = cmd.turn;
                    face_next = cmd.face;
                    dir_next  = dir_c;
                    upc_next  = act_entry(cmd.action);
                end
            end
            OP_RESET:
            begin
                emit_req      = 1'b1;
                res_next.last = 1'b1;
                ori_next      = ORI_IDENT;
                if (slot_free)
                begin
                    upc_next = uw_c.next;
                end
            end
            OP_ROBOT:
            begin
                emit_req      = 1'b1;
                res_next.last = 1'b1;
                if (robot_bad)
                begin
                    res_next.status = 1'b1;
                end
                else
                begin
                    res_next.move_valid = 1'b1;
                    res_next.move_axis  = axis_reg;
                    res_next.move_turn  = turn_reg;
                    ori_next            = apply_move(ori_reg, axis_reg, turn_reg);
                end
                if (slot_free)
                begin
                    upc_next = uw_c.next;
                end
            end
            OP_CUBE_CHK:
            begin
                if (cube_bad)
                begin
                    emit_req        = 1'b1;
                    res_next.status = 1'b1;
                    res_next.last   = 1'b1;
                    if (slot_free)
                    begin
                        upc_next = uw_c.alt;
                    end
                end
                else
                begin
                    upc_next = dir_entry(dir_reg);
                end
            end
            OP_FIX:
            begin
                emit_req            = 1'b1;
                res_next.move_valid = 1'b1;
                res_next.move_axis  = uw_c.axis;
                res_next.move_turn  = uw_c.turn;
                ori_next            = apply_move(ori_reg, uw_c.axis, uw_c.turn);
                if (slot_free)
                begin
                    upc_next = uw_c.next;
                end
            end
            OP_DMOVE:
            begin
                emit_req            = 1'b1;
                res_next.move_valid = 1'b1;
                res_next.move_axis  = uw_c.axis;
                res_next.move_turn  = turn_reg;
                res_next.last       = 1'b1;
                if (slot_free)
                begin
                    upc_next = uw_c.next;
                end
            end
            OP_R_INIT:
            begin
                if (ori_reg == ORI_IDENT)
                begin
                    emit_req      = 1'b1;
                    res_next.last = 1'b1;
                    if (slot_free)
                    begin
                        upc_next = uw_c.alt;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = sidx_t'(1);
                    head_next  = '0;
                    n_next     = '0;
                    upc_next   = uw_c.next;
                end
            end
            OP_R_READ:
            begin
                if (head_reg == count_reg)
                begin
                    upc_next = uw_c.alt;
                end
                else
                begin
                    rd_cur       = 1'b1;
                    cur_idx_next = head_reg;
                    head_next    = head_reg + sidx_t'(1);
                    m_next       = RK_YP;
                    upc_next     = uw_c.next;
                end
            end
            OP_R_EXP:
            begin
                if (seen_c)
                begin
                    if (m_reg == RK_ZM)
                    begin
                        upc_next = uw_c.next;
                    end
                    else
                    begin
                        m_next = m_reg + 2'd1;
                    end
                end
                else if (count_reg >= sidx_t'(NUM_ORI))
                begin
                    upc_next = uw_c.next;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg;
                    wr_state   = p_c;
                    wr_parent  = cur_idx_reg;
                    wr_move    = m_reg;
                    count_next = count_reg + sidx_t'(1);
                    if (p_c == ORI_IDENT)
                    begin
                        c_next   = count_reg;
                        upc_next = uw_c.alt;
                    end
                    else if (m_reg == RK_ZM)
                    begin
                        upc_next = uw_c.next;
                    end
                    else
                    begin
                        m_next = m_reg + 2'd1;
                    end
                end
            end
            OP_R_BREAD:
            begin
                if (c_reg == '0)
                begin
                    upc_next = uw_c.alt;
                end
                else
                begin
                    rd_back  = 1'b1;
                    upc_next = uw_c.next;
                end
            end
            OP_R_BSTEP:
            begin
                if (n_reg < PATH_NW'(PATH_DEPTH))
                begin
                    path_we = 1'b1;
                    n_next  = n_reg + PATH_NW'(1);
                end
                c_next   = par_rd_reg;
                upc_next = uw_c.next;
            end
            OP_R_EMIT:
            begin
                emit_req            = 1'b1;
                res_next.move_valid = 1'b1;
                res_next.move_axis  = path_mv_c[1] ? AX_Z : AX_Y;
                res_next.move_turn  = {1'b0, path_mv_c[0]};
                res_next.last       = (n_reg == PATH_NW'(1));
                ori_next            = apply_move(ori_reg, res_next.move_axis,
                                                 res_next.move_turn);
                if (slot_free)
                begin
                    n_next = nm1_c;
                    if (n_reg == PATH_NW'(1))
                    begin
                        upc_next = uw_c.next;
                    end
                end
            end
            OP_R_FAIL:
            begin
                emit_req        = 1'b1;
                res_next.status = 1'b1;
                res_next.last   = 1'b1;
                if (slot_free)
                begin
                    upc_next = uw_c.next;
                end
            end
            default:
            begin
                upc_next = A_FETCH;
            end
        endcase

        res_next.faces = ori_next;

        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_FETCH;
            ori_reg       <= ORI_IDENT;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            cur_idx_reg   <= '0;
            m_reg         <= RK_YP;
            c_reg         <= '0;
            n_reg         <= '0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cur_idx_reg   <= cur_idx_next;
            m_reg         <= m_next;
            c_reg         <= c_next;
            n_reg         <= n_next;
            if (emit_go)
            begin
                ori_reg <= ori_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg <= axis_next;
        turn_reg <= turn_next;
        face_reg <= face_next;
        dir_reg  <= dir_next;
        if (emit_go)
        begin
            res_reg <= res_next;
        end
        if (wr_en)
        begin
            states_mem[wr_addr] <= wr_state;
            parent_mem[wr_addr] <= wr_parent;
            move_mem[wr_addr]   <= wr_move;
        end
        if (rd_cur)
        begin
            cur_reg <= states_mem[head_reg];
        end
        if (rd_back)
        begin
            par_rd_reg <= parent_mem[c_reg];
            mv_rd_reg  <= move_mem[c_reg];
        end
        if (path_we)
        begin
            path_mem[n_reg[PATH_IW-1:0]] <= mv_rd_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.move_valid    = res_reg.move_valid;
    assign res.move_axis     = res_reg.move_axis;
    assign res.move_turn     = res_reg.move_turn;
    assign res.status        = res_reg.status;
    assign res.last          = res_reg.last;
    assign res.face_at_up    = res_reg.faces[DIR_U];
    assign res.face_at_down  = res_reg.faces[DIR_D];
    assign res.face_at_front = res_reg.faces[DIR_F];
    assign res.face_at_back  = res_reg.faces[DIR_B];
    assign res.face_at_left  = res_reg.faces[DIR_L];
    assign res.face_at_right = res_reg.faces[DIR_R];

    logic [NUM_DIR-1:0] face_seen;

    always_comb
    begin
        face_seen = '0;
        for (int i = 0; i < NUM_DIR; i++)
        begin
            if (ori_reg[i] <= FACE_MAX)
            begin
                face_seen[ori_reg[i]] = 1'b1;
            end
        end
    end

    a_ori_perm: assert property (@(posedge clk) disable iff (!rst_n) &face_seen)
        else $error("orientation is no longer a permutation of the six faces");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sidx_t'(NUM_ORI) && head_reg <= count_reg)
        else $error("search queue pointers out of range");

    a_restore_home: assert property (@(posedge clk) disable iff (!rst_n)
        (uw_c.op == OP_R_EMIT && emit_go && n_reg == PATH_NW'(1)) |=> ori_reg == ORI_IDENT)
        else $error("restore path did not end at the home orientation");

    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg < upc_t'(PROG_LEN))
        else $error("step counter left the control store");

endmodule
